@@ design/cte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_pkg
// Shared widths, constants, stage types and the month table for the civil
// time to epoch converter.
// ----------------------------------------------------------------------------
package cte_pkg;

    // Field widths of one timestamp and of one result.
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int ZONE_W   = 5;
    localparam int EPOCH_W  = 34;

    // Internal widths.
    localparam int QUOT_W  = 6;   // year / 100 for a 12-bit year
    localparam int COUNT_W = 21;  // signed day count since the epoch
    localparam int TOD_W   = 19;  // signed seconds of the day, zone applied
    localparam int PROD_W  = 40;  // signed seconds before saturation

    // Calendar constants.
    localparam int SECS_PER_DAY       = 86400;
    localparam int SECS_PER_HOUR      = 3600;
    localparam int SECS_PER_MINUTE    = 60;
    localparam int EPOCH_YEAR         = 1970;
    localparam int CENTURY_BASE       = 2000;
    localparam int CENTURY_LIMIT      = 100;
    localparam int DAYS_PER_YEAR      = 365;
    localparam int LEAPS_BEFORE_EPOCH = 477;  // leap years in 1..1969

    // Division by 100 of a 12-bit value: (v * 5243) >> 19 is exact there.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PW    = YEAR_W + 13;

    // One timestamp as it arrives.
    typedef struct packed {
        logic [YEAR_W-1:0]          year;
        logic [MONTH_W-1:0]         month;
        logic [DAY_W-1:0]           day;
        logic [HOUR_W-1:0]          hour;
        logic [MINUTE_W-1:0]        minute;
        logic [SECOND_W-1:0]        second;
        logic signed [ZONE_W-1:0]   zone;
    } t_stamp;

    // Day count and time of day handed to the seconds stages.
    typedef struct packed {
        logic signed [COUNT_W-1:0]  days;
        logic signed [TOD_W-1:0]    tod;
    } t_day_count;

    // Days before the first of a month in a common year. Month zero counts
    // as January and months above twelve count as December.
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            default:    d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

@@ design/cte_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_in_if
// Valid/ready channel carrying one parsed civil timestamp per transfer.
// ----------------------------------------------------------------------------
interface cte_in_if;
    import cte_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [YEAR_W-1:0]          year_value;
    logic [MONTH_W-1:0]         month_value;
    logic [DAY_W-1:0]           day_value;
    logic [HOUR_W-1:0]          hour_value;
    logic [MINUTE_W-1:0]        minute_value;
    logic [SECOND_W-1:0]        second_value;
    logic signed [ZONE_W-1:0]   zone_hours;

    modport source (
        output valid, year_value, month_value, day_value, hour_value,
               minute_value, second_value, zone_hours,
        input  ready
    );

    modport sink (
        input  valid, year_value, month_value, day_value, hour_value,
               minute_value, second_value, zone_hours,
        output ready
    );
endinterface

@@ design/cte_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_out_if
// Valid/ready channel carrying one epoch second count per transfer.
// ----------------------------------------------------------------------------
interface cte_out_if;
    import cte_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [EPOCH_W-1:0]  epoch_seconds;

    modport source (
        output valid, epoch_seconds,
        input  ready
    );

    modport sink (
        input  valid, epoch_seconds,
        output ready
    );
endinterface

@@ design/cte_day_count.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_day_count
// Three pipeline stages that turn a civil timestamp into a signed day count
// since the epoch and the zone-corrected seconds of the day.
// ----------------------------------------------------------------------------
module cte_day_count (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  cte_pkg::t_stamp         i_stamp,
    output logic                    o_valid,
    input  logic                    i_ready,
    output cte_pkg::t_day_count     o_count
);
    import cte_pkg::*;

    // Stage one holds the full year and its quotients by 100.
    typedef struct packed {
        logic [YEAR_W-1:0]          year;
        logic [QUOT_W-1:0]          q_year;
        logic [QUOT_W-1:0]          q_prev;
        t_stamp                     stamp;
    } t_s1;

    // Stage two holds the year span, leap count and month offset.
    typedef struct packed {
        logic [YEAR_W-1:0]          span;
        logic [YEAR_W-1:0]          leaps;
        logic [8:0]                 month_days;
        logic [DAY_W-1:0]           day;
        logic signed [TOD_W-1:0]    tod;
    } t_s2;

    logic       r_v1, r_v2, r_v3;
    logic       w_rdy1, w_rdy2, w_rdy3;
    t_s1        r_s1, n_s1;
    t_s2        r_s2, n_s2;
    t_day_count r_s3, n_s3;

    // A stage takes new data when it is empty or its successor moves on.
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_count = r_s3;

    // Stage one: century fold and the reciprocal multiplications by 1/100.
    logic [YEAR_W-1:0]      w_year;
    logic [YEAR_W-1:0]      w_prev;
    logic [DIV100_PW-1:0]   w_prod_year;
    logic [DIV100_PW-1:0]   w_prod_prev;

    always_comb begin
        w_year = (i_stamp.year < YEAR_W'(CENTURY_LIMIT))
               ? i_stamp.year + YEAR_W'(CENTURY_BASE) : i_stamp.year;
        w_prev = w_year - YEAR_W'(1);
        w_prod_year = DIV100_PW'(w_year) * DIV100_PW'(DIV100_MUL);
        w_prod_prev = DIV100_PW'(w_prev) * DIV100_PW'(DIV100_MUL);
        n_s1.year   = w_year;
        n_s1.q_year = w_prod_year[DIV100_SHIFT +: QUOT_W];
        n_s1.q_prev = w_prod_prev[DIV100_SHIFT +: QUOT_W];
        n_s1.stamp  = i_stamp;
    end

    // Stage two: leap rule, leap count through last year, month offset and
    // the seconds of the day with the zone taken off.
    logic [YEAR_W-1:0]          w_hundreds;
    logic [YEAR_W-1:0]          w_last;
    logic                       w_century;
    logic                       w_leap;
    logic signed [6:0]          w_hz;
    logic [11:0]                w_ms;

    always_comb begin
        w_hundreds = YEAR_W'(r_s1.q_year) * YEAR_W'(CENTURY_LIMIT);
        w_century  = (r_s1.year == w_hundreds);
        w_leap     = (r_s1.year[1:0] == 2'b00 && !w_century)
                   || (w_century && r_s1.q_year[1:0] == 2'b00);
        w_last     = r_s1.year - YEAR_W'(1);
        n_s2.leaps = YEAR_W'(w_last[YEAR_W-1:2]) - YEAR_W'(r_s1.q_prev)
                   + YEAR_W'(r_s1.q_prev[QUOT_W-1:2]);
        n_s2.span  = (r_s1.year > YEAR_W'(EPOCH_YEAR))
                   ? r_s1.year - YEAR_W'(EPOCH_YEAR) : '0;
        n_s2.month_days = days_before_month(r_s1.stamp.month)
                   + 9'((w_leap && r_s1.stamp.month > MONTH_W'(2)) ? 1 : 0);
        n_s2.day   = r_s1.stamp.day;
        w_hz       = $signed({2'b00, r_s1.stamp.hour}) - 7'(r_s1.stamp.zone);
        w_ms       = 12'(r_s1.stamp.minute) * 12'(SECS_PER_MINUTE)
                   + 12'(r_s1.stamp.second);
        n_s2.tod   = TOD_W'(w_hz) * TOD_W'(SECS_PER_HOUR)
                   + $signed({{(TOD_W-12){1'b0}}, w_ms});
    end

    // Stage three: whole years, leap days, month days and the day itself.
    logic [COUNT_W-1:0] w_span_days;
    logic [COUNT_W-1:0] w_leap_days;

    always_comb begin
        w_span_days = COUNT_W'(r_s2.span) * COUNT_W'(DAYS_PER_YEAR);
        w_leap_days = (r_s2.span != '0)
                    ? COUNT_W'(r_s2.leaps) - COUNT_W'(LEAPS_BEFORE_EPOCH) : '0;
        n_s3.days   = $signed(w_span_days + w_leap_days + COUNT_W'(r_s2.month_days)
                    + COUNT_W'(r_s2.day) - COUNT_W'(1));
        n_s3.tod    = r_s2.tod;
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // Stage data, loaded only on a move of live data.
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) r_s1 <= n_s1;
        if (w_rdy2 && r_v1)    r_s2 <= n_s2;
        if (w_rdy3 && r_v2)    r_s3 <= n_s3;
    end

endmodule

@@ design/civil_time_to_epoch_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_time_to_epoch_core
// Gregorian civil date and time with a whole-hour zone offset to signed
// Unix epoch seconds, saturated to 34 bits.
// ----------------------------------------------------------------------------
// The converter is a five-stage pipeline: it accepts one timestamp in every
// cycle unless back-pressure holds it, and delivers the results in input
// order. Stages one to three work out the leap rule, the leap count
// (by reciprocal multiplication by 1/100) and the day count; stage four
// multiplies the day count by 86400; stage five adds the time of day and
// saturates into the output register. A stall at the output holds every
// stage that is full and lets empty stages keep filling, so back-pressure
// reaches the input only once the whole pipeline is occupied.
module civil_time_to_epoch_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cte_in_if.sink      i_in,
    cte_out_if.source   o_out
);
    import cte_pkg::*;

    localparam logic signed [PROD_W-1:0] EPOCH_MAX = PROD_W'(64'sd8589934591);
    localparam logic signed [PROD_W-1:0] EPOCH_MIN = PROD_W'(-64'sd8589934592);

    typedef struct packed {
        logic signed [PROD_W-1:0]   prod;
        logic signed [TOD_W-1:0]    tod;
    } t_s4;

    t_stamp                     w_stamp;
    t_day_count                 w_count;
    logic                       w_count_valid;
    logic                       w_count_ready;
    logic                       r_v4, r_v5;
    logic                       w_rdy4, w_rdy5;
    t_s4                        r_s4, n_s4;
    logic signed [EPOCH_W-1:0]  r_epoch, n_epoch;
    logic signed [PROD_W-1:0]   w_sum;

    // Input transfer payload gathered into one word.
    always_comb begin
        w_stamp.year   = i_in.year_value;
        w_stamp.month  = i_in.month_value;
        w_stamp.day    = i_in.day_value;
        w_stamp.hour   = i_in.hour_value;
        w_stamp.minute = i_in.minute_value;
        w_stamp.second = i_in.second_value;
        w_stamp.zone   = i_in.zone_hours;
    end

    cte_day_count u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_stamp (w_stamp),
        .o_valid (w_count_valid),
        .i_ready (w_count_ready),
        .o_count (w_count)
    );

    // Ready chain of the two seconds stages.
    assign w_rdy5        = !r_v5 || o_out.ready;
    assign w_rdy4        = !r_v4 || w_rdy5;
    assign w_count_ready = w_rdy4;

    // Stage four: days to seconds.
    always_comb begin
        n_s4.prod = PROD_W'(w_count.days) * PROD_W'(SECS_PER_DAY);
        n_s4.tod  = w_count.tod;
    end

    // Stage five: add the time of day and clamp to the 34-bit range.
    always_comb begin
        w_sum = r_s4.prod + PROD_W'(r_s4.tod);
        if (w_sum > EPOCH_MAX) begin
            n_epoch = EPOCH_MAX[EPOCH_W-1:0];
        end else if (w_sum < EPOCH_MIN) begin
            n_epoch = EPOCH_MIN[EPOCH_W-1:0];
        end else begin
            n_epoch = w_sum[EPOCH_W-1:0];
        end
    end

    // Valid bits of the seconds stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy4) r_v4 <= w_count_valid;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        if (w_rdy4 && w_count_valid) r_s4    <= n_s4;
        if (w_rdy5 && r_v4)          r_epoch <= n_epoch;
    end

    assign o_out.valid         = r_v5;
    assign o_out.epoch_seconds = r_epoch;

endmodule

@@ sim/civil_time_to_epoch_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_time_to_epoch_core_tb
// Self-checking bench for the civil time to epoch converter. Timestamps are
// sent over the input channel with random gaps, and each one is converted by
// a behavioral calendar model into the epoch second count it should produce.
// Each output transfer is compared against the oldest pending count. Directed
// corner dates are followed by random traffic, a full-pipeline back-pressure
// phase, drained bursts and back-to-back streaming.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_core_tb;
    import cte_pkg::*;

    localparam int     CLK_HALF        = 4;
    localparam int     RESET_CYCLES    = 7;
    localparam int     CYCLE_LIMIT     = 500000;
    localparam int     MONTHS_PER_YEAR = 12;
    localparam int     PIPE_LATENCY    = 5;
    localparam longint EPOCH_MAX       = (64'sd1 <<< (EPOCH_W - 1)) - 1;
    localparam longint EPOCH_MIN       = -(64'sd1 <<< (EPOCH_W - 1));

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cte_in_if  in_if ();
    cte_out_if out_if ();

    civil_time_to_epoch_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Days before the first of each month in a common year.
    int month_start_days [MONTHS_PER_YEAR] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    logic signed [EPOCH_W-1:0] awaited_epochs [$];
    int  error_count   = 0;
    int  cycle_count   = 0;
    bit  idle_on       = 1'b1;   // random gaps on both sides
    int  hold_request  = 0;      // long output stall asked by a test
    int  hold_left     = 0;
    int  stall_left    = 0;

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Run-length guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Leap years in 1..n.
    function automatic longint leaps_through(input longint n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // Calendar arithmetic for one timestamp, saturated to the output width.
    function automatic logic signed [EPOCH_W-1:0] civil_to_epoch(input t_stamp s);
        longint year;
        longint month;
        longint zone;
        longint days;
        longint secs;
        bit     leap;
        year = s.year;
        if (year < CENTURY_LIMIT)
            year += CENTURY_BASE;
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        days = 0;
        if (year > EPOCH_YEAR)
            days = DAYS_PER_YEAR * (year - EPOCH_YEAR)
                 + leaps_through(year - 1) - leaps_through(EPOCH_YEAR - 1);
        month = (s.month > MONTHS_PER_YEAR) ? MONTHS_PER_YEAR : s.month;
        if (month >= 1) begin
            days += month_start_days[month - 1];
            if (month > 2 && leap)
                days += 1;
        end
        days += longint'(s.day) - 1;
        zone = $signed(s.zone);
        secs = days * SECS_PER_DAY
             + longint'(s.hour) * SECS_PER_HOUR
             + longint'(s.minute) * SECS_PER_MINUTE
             + longint'(s.second)
             - zone * SECS_PER_HOUR;
        if (secs > EPOCH_MAX)
            secs = EPOCH_MAX;
        if (secs < EPOCH_MIN)
            secs = EPOCH_MIN;
        return secs[EPOCH_W-1:0];
    endfunction

    function automatic t_stamp make_stamp(input int y, input int mo, input int d,
                                          input int h, input int mi, input int sec,
                                          input int z);
        t_stamp s;
        s.year   = YEAR_W'(y);
        s.month  = MONTH_W'(mo);
        s.day    = DAY_W'(d);
        s.hour   = HOUR_W'(h);
        s.minute = MINUTE_W'(mi);
        s.second = SECOND_W'(sec);
        s.zone   = ZONE_W'(z);
        return s;
    endfunction

    // Mostly plausible timestamps, with every field now and then taking any
    // value its width allows. Century years and the months of February and
    // March are favored so that the leap rule gets exercised.
    function automatic t_stamp random_stamp();
        t_stamp s;
        int     pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       s.year = YEAR_W'($urandom);
            1:       s.year = YEAR_W'($urandom_range(0, 99));
            2:       s.year = YEAR_W'($urandom_range(100, 1969));
            3:       s.year = YEAR_W'(100 * $urandom_range(19, 40));
            default: s.year = YEAR_W'($urandom_range(1970, 2199));
        endcase
        if ($urandom_range(0, 9) == 0)
            s.month = MONTH_W'($urandom);
        else if ($urandom_range(0, 3) == 0)
            s.month = MONTH_W'($urandom_range(2, 3));
        else
            s.month = MONTH_W'($urandom_range(1, 12));
        s.day    = ($urandom_range(0, 9) == 0) ? DAY_W'($urandom)
                                               : DAY_W'($urandom_range(1, 31));
        s.hour   = ($urandom_range(0, 9) == 0) ? HOUR_W'($urandom)
                                               : HOUR_W'($urandom_range(0, 23));
        s.minute = ($urandom_range(0, 9) == 0) ? MINUTE_W'($urandom)
                                               : MINUTE_W'($urandom_range(0, 59));
        s.second = ($urandom_range(0, 9) == 0) ? SECOND_W'($urandom)
                                               : SECOND_W'($urandom_range(0, 60));
        s.zone   = ($urandom_range(0, 9) == 0) ? ZONE_W'($urandom)
                                               : ZONE_W'(int'($urandom_range(0, 26)) - 12);
        return s;
    endfunction

    // Offers one timestamp and waits for its transfer. Called and returns on
    // a falling edge; valid stays high when the next call has no gap.
    task automatic send_stamp(input t_stamp s);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.year_value   = s.year;
        in_if.month_value  = s.month;
        in_if.day_value    = s.day;
        in_if.hour_value   = s.hour;
        in_if.minute_value = s.minute;
        in_if.second_value = s.second;
        in_if.zone_hours   = s.zone;
        in_if.valid        = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        awaited_epochs.push_back(civil_to_epoch(s));
        @(negedge i_clk);
    endtask

    // Sender pause until every pending result has come out.
    task automatic wait_for_drain();
        in_if.valid = 1'b0;
        while (awaited_epochs.size() != 0)
            @(negedge i_clk);
    endtask

    // Output side: per-transfer random stalls plus an optional long hold.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            out_if.ready = 1'b0;
            hold_left    = hold_left - 1;
        end else if (stall_left > 0) begin
            out_if.ready = 1'b0;
            stall_left   = stall_left - 1;
        end else begin
            out_if.ready = 1'b1;
        end
    end

    // Compare each output transfer with the oldest pending count.
    always @(posedge i_clk) begin
        logic signed [EPOCH_W-1:0] want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (awaited_epochs.size() == 0) begin
                $error("epoch_seconds: unexpected result %0d", out_if.epoch_seconds);
                error_count++;
            end else begin
                want = awaited_epochs.pop_front();
                if (out_if.epoch_seconds !== want) begin
                    $error("epoch_seconds: expected %0d, actual %0d",
                           want, out_if.epoch_seconds);
                    error_count++;
                end
            end
            stall_left = idle_on ? $urandom_range(0, 15) : 0;
        end
    end

    // Epoch origin, century mapping, leap rule, out-of-range fields and
    // saturation, sent in sequence and then drained.
    task automatic test_corner_dates();
        send_stamp(make_stamp(1970,  1,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(   0,  1,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(  99, 12, 31, 23, 59, 59,   0));
        send_stamp(make_stamp( 100,  1,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(1969, 12, 31, 23, 59, 59,   0));
        send_stamp(make_stamp(1971,  1,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(2000,  3,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(1900,  3,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(2100,  3,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(2400,  3,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(2024,  0, 15,  8,  0,  0,   1));
        send_stamp(make_stamp(2023, 13,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(2024, 15,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(1970,  1,  0,  0,  0,  0,  15));
        send_stamp(make_stamp(2038,  1, 19,  3, 14,  7,   0));
        send_stamp(make_stamp(2030,  6, 31, 31, 63, 63, -16));
        send_stamp(make_stamp(2030,  6, 15, 12, 30, 60, -12));
        send_stamp(make_stamp(2030,  6, 15, 12, 30,  0,  14));
        send_stamp(make_stamp(2199, 12, 31, 23, 59, 59, -12));
        send_stamp(make_stamp(2242, 12, 31, 23, 59, 59,   0));
        send_stamp(make_stamp(2243,  1,  1,  0,  0,  0,   0));
        send_stamp(make_stamp(4095, 15, 31, 31, 63, 63, -16));
        wait_for_drain();
    endtask

    // Random traffic with random gaps on both sides, broken into stretches
    // where neither side idles.
    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 200 == 150)
                idle_on = 1'b0;
            else if (n % 200 == 0)
                idle_on = 1'b1;
            send_stamp(random_stamp());
        end
        idle_on = 1'b1;
    endtask

    // Long output hold while the input keeps offering, so the pipeline fills
    // and the input stalls.
    task automatic test_full_pipeline(input int count);
        idle_on      = 1'b0;
        hold_request = 300;
        for (int n = 0; n < count; n++)
            send_stamp(random_stamp());
        idle_on = 1'b1;
        wait_for_drain();
    endtask

    // Short bursts, each drained before the next one starts.
    task automatic test_drained_bursts(input int bursts, input int len);
        for (int b = 0; b < bursts; b++) begin
            for (int n = 0; n < len; n++)
                send_stamp(random_stamp());
            wait_for_drain();
        end
    endtask

    // One transfer per cycle on both channels.
    task automatic test_streaming(input int count);
        idle_on = 1'b0;
        for (int n = 0; n < count; n++)
            send_stamp(random_stamp());
        idle_on = 1'b1;
    endtask

    initial begin
        in_if.valid        = 1'b0;
        in_if.year_value   = '0;
        in_if.month_value  = '0;
        in_if.day_value    = '0;
        in_if.hour_value   = '0;
        in_if.minute_value = '0;
        in_if.second_value = '0;
        in_if.zone_hours   = '0;
        out_if.ready       = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_corner_dates();
        test_random_traffic(1300);
        test_full_pipeline(60);
        test_drained_bursts(8, 30);
        test_streaming(300);

        // Let the last results out and watch for any extra transfer.
        wait_for_drain();
        repeat (4 * PIPE_LATENCY) @(negedge i_clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
